/* hdl/chm_pkg.sv */
package chm_pkg;

	localparam int DEF_BUCKETS = 256;
	localparam int DEF_NODES   = 1024;
	localparam int CNT_W       = 9;
	localparam int KEY_W       = 32;
	localparam int VAL_W       = 32;
	localparam int ENT_W       = 11;
	localparam logic [KEY_W-1:0] HASH_MUL = 32'd1101524993;
	localparam logic [CNT_W-1:0] CNT_RESET = 9'd256;

	typedef enum logic [1:0] {
		FN_INSERT = 2'd0,
		FN_FIND   = 2'd1,
		FN_REMOVE = 2'd2,
		FN_CLEAR  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_HEAD,
		S_WALK,
		S_NODE,
		S_ACT,
		S_POP,
		S_FIN
	} state_t;

	typedef struct packed {
		logic clear;
		logic pop;
		logic push;
	} pool_ctl_t;

	typedef struct packed {
		logic rd;
		logic kv_we;
		logic link_we;
	} node_ctl_t;

endpackage

/* hdl/chm_ifs.sv */
interface chm_req_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    func;
	logic [chm_pkg::KEY_W-1:0]     key;
	logic [chm_pkg::VAL_W-1:0]     value;
	modport source (output valid, func, key, value, input ready);
	modport sink   (input valid, func, key, value, output ready);
endinterface

interface chm_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    status;
	logic                          found;
	logic [chm_pkg::VAL_W-1:0]     value_out;
	logic [chm_pkg::ENT_W-1:0]     entries_stored;
	modport source (output valid, status, found, value_out, entries_stored, input ready);
	modport sink   (input valid, status, found, value_out, entries_stored, output ready);
endinterface

interface chm_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [chm_pkg::CNT_W-1:0]     data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

/* hdl/chm_hash_unit.sv */
module chm_hash_unit #(
	parameter int BUCKETS = chm_pkg::DEF_BUCKETS,
	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [chm_pkg::KEY_W-1:0]  key,
	input  logic [chm_pkg::CNT_W-1:0]  n,
	output logic                       done,
	output logic [BW-1:0]              bucket
);

	logic [chm_pkg::KEY_W-1:0] h_q;
	logic [chm_pkg::CNT_W-1:0] rem_q;
	logic [4:0]                cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [chm_pkg::CNT_W:0]   trial;

	assign trial = {rem_q, h_q[chm_pkg::KEY_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division, one quotient bit per cycle; only the remainder is kept
	always_ff @(posedge clk) begin
		if (start) begin
			h_q   <= key * chm_pkg::HASH_MUL;
			rem_q <= '0;
		end else if (busy_q) begin
			h_q <= {h_q[chm_pkg::KEY_W-2:0], 1'b0};
			if (trial >= {1'b0, n})
				rem_q <= chm_pkg::CNT_W'(trial - {1'b0, n});
			else
				rem_q <= trial[chm_pkg::CNT_W-1:0];
		end
	end

	assign done   = done_q;
	assign bucket = BW'(rem_q);

endmodule

/* hdl/chm_node_store.sv */
module chm_node_store #(
	parameter int NODES = chm_pkg::DEF_NODES,
	localparam int IW = (NODES > 1) ? $clog2(NODES) : 1,
	localparam int NW = $clog2(NODES + 1)
) (
	input  logic                       clk,
	input  chm_pkg::node_ctl_t         ctl,
	input  logic [IW-1:0]              rd_addr,
	input  logic [IW-1:0]              kv_addr,
	input  logic [chm_pkg::KEY_W-1:0]  kv_key,
	input  logic [chm_pkg::VAL_W-1:0]  kv_val,
	input  logic [IW-1:0]              link_addr,
	input  logic [NW-1:0]              link_data,
	output logic [chm_pkg::KEY_W-1:0]  rd_key,
	output logic [chm_pkg::VAL_W-1:0]  rd_val,
	output logic [NW-1:0]              rd_link
);

	logic [chm_pkg::KEY_W+chm_pkg::VAL_W-1:0] kv_mem [NODES];
	logic [NW-1:0]                            link_mem [NODES];
	logic [chm_pkg::KEY_W+chm_pkg::VAL_W-1:0] kv_rd_q;
	logic [NW-1:0]                            link_rd_q;

	always_ff @(posedge clk) begin
		if (ctl.kv_we)
			kv_mem[kv_addr] <= {kv_key, kv_val};
		if (ctl.rd)
			kv_rd_q <= kv_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (ctl.link_we)
			link_mem[link_addr] <= link_data;
		if (ctl.rd)
			link_rd_q <= link_mem[rd_addr];
	end

	assign rd_key  = kv_rd_q[chm_pkg::KEY_W+chm_pkg::VAL_W-1:chm_pkg::VAL_W];
	assign rd_val  = kv_rd_q[chm_pkg::VAL_W-1:0];
	assign rd_link = link_rd_q;

endmodule

/* hdl/chm_free_pool.sv */
module chm_free_pool #(
	parameter int NODES = chm_pkg::DEF_NODES,
	localparam int IW = (NODES > 1) ? $clog2(NODES) : 1,
	localparam int NW = $clog2(NODES + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  chm_pkg::pool_ctl_t ctl,
	input  logic [IW-1:0]      push_node,
	output logic [IW-1:0]      pop_node,
	output logic [NW-1:0]      total
);

	localparam logic [NW-1:0] FULL = NW'(NODES);

	logic [IW-1:0] mem [NODES];
	logic [IW-1:0] rd_q;
	logic [IW-1:0] pos_q;
	logic          fresh_q;
	logic [NW-1:0] ft_q;
	logic [NW-1:0] lw_q;   // lowest stack depth since clear; slots below it still hold identity
	logic [NW-1:0] ft_dec;

	assign ft_dec = ft_q - NW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ft_q <= FULL;
			lw_q <= FULL;
		end else if (ctl.clear) begin
			ft_q <= FULL;
			lw_q <= FULL;
		end else if (ctl.pop) begin
			ft_q <= ft_dec;
			if (ft_dec < lw_q)
				lw_q <= ft_dec;
		end else if (ctl.push && ft_q < FULL) begin
			ft_q <= ft_q + NW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			rd_q    <= mem[ft_dec[IW-1:0]];
			pos_q   <= ft_dec[IW-1:0];
			fresh_q <= (ft_dec < lw_q);
		end
		if (ctl.push && ft_q < FULL)
			mem[ft_q[IW-1:0]] <= push_node;
	end

	assign pop_node = fresh_q ? pos_q : rd_q;
	assign total    = ft_q;

endmodule

/* hdl/chained_hash_map_top.sv */
// channel   dir  payload                                   accepted when
// req       in   func, key, value                          valid && ready
// rsp       out  status, found, value_out, entries_stored  valid && ready
// cfg       in   data (bucket_count)                       valid && ready
//
// Clear goes from accept straight to the output load. Other operations pass through
// accept and multiply, 32 remainder steps, a done step, the head read, then per chain
// node a walk step and a node compare, a last walk step unless the key is hit, the
// action and the output load. Insert of a new key adds one pool read step.
// Reset empties all buckets at once (per-bucket valid bits); no clearing pass.
// A finished word is held in the output register while the next request runs.
module chained_hash_map_top #(
	parameter int BUCKETS = chm_pkg::DEF_BUCKETS,
	parameter int NODES   = chm_pkg::DEF_NODES
) (
	input  logic      clk,
	input  logic      arst_n,
	chm_req_if.sink   req,
	chm_rsp_if.source rsp,
	chm_cfg_if.sink   cfg
);

	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int NW = $clog2(NODES + 1);
	localparam logic [NW-1:0] NODE_END = NW'(NODES);

	chm_pkg::state_t st_q, st_d;
	chm_pkg::func_t  func_q;
	logic [chm_pkg::CNT_W-1:0] cnt_q;
	logic [chm_pkg::CNT_W-1:0] n_act;
	logic [chm_pkg::KEY_W-1:0] key_q;
	logic [chm_pkg::VAL_W-1:0] val_q;

	logic          hash_start, hash_done;
	logic [BW-1:0] bucket;

	logic [NW-1:0]      head_mem [BUCKETS];
	logic [BUCKETS-1:0] hvalid_q;
	logic [NW-1:0]      head_rd_q;
	logic               head_rd, head_we;
	logic [NW-1:0]      head_wdata;

	logic [NW-1:0] cur_q, prev_q, head_q, nlink_q, steps_q;
	logic [chm_pkg::VAL_W-1:0] nval_q;
	logic walk_end;

	chm_pkg::node_ctl_t node_ctl;
	logic [IW-1:0] link_addr;
	logic [NW-1:0] link_data;
	logic [IW-1:0] kv_addr;
	logic [chm_pkg::KEY_W-1:0] rd_key;
	logic [chm_pkg::VAL_W-1:0] rd_val;
	logic [NW-1:0] rd_link;

	chm_pkg::pool_ctl_t pool_ctl;
	logic [IW-1:0] pop_node;
	logic [NW-1:0] ft;

	chm_pkg::status_t status_q;
	logic found_q;
	logic [chm_pkg::VAL_W-1:0] vout_q;
	logic ov_q;
	logic out_load;
	logic req_go;

	// bucket count register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= chm_pkg::CNT_RESET;
		else if (cfg.valid)
			cnt_q <= cfg.data;
	end

	always_comb begin
		if (cnt_q == '0)
			n_act = chm_pkg::CNT_W'(1);
		else if (32'(cnt_q) > 32'(BUCKETS))
			n_act = chm_pkg::CNT_W'(BUCKETS);
		else
			n_act = cnt_q;
	end

	assign req.ready = (st_q == chm_pkg::S_IDLE);
	assign req_go    = req.valid && req.ready;
	assign walk_end  = (cur_q >= NODE_END) || (steps_q == NODE_END);
	assign out_load  = (st_q == chm_pkg::S_FIN) && (!ov_q || rsp.ready);

	chm_hash_unit #(.BUCKETS(BUCKETS)) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (req.key),
		.n      (n_act),
		.done   (hash_done),
		.bucket (bucket)
	);

	chm_node_store #(.NODES(NODES)) u_nodes (
		.clk       (clk),
		.ctl       (node_ctl),
		.rd_addr   (cur_q[IW-1:0]),
		.kv_addr   (kv_addr),
		.kv_key    (key_q),
		.kv_val    (val_q),
		.link_addr (link_addr),
		.link_data (link_data),
		.rd_key    (rd_key),
		.rd_val    (rd_val),
		.rd_link   (rd_link)
	);

	chm_free_pool #(.NODES(NODES)) u_pool (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (pool_ctl),
		.push_node (cur_q[IW-1:0]),
		.pop_node  (pop_node),
		.total     (ft)
	);

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			chm_pkg::S_IDLE: begin
				if (req_go)
					st_d = (chm_pkg::func_t'(req.func) == chm_pkg::FN_CLEAR) ?
						chm_pkg::S_FIN : chm_pkg::S_DIV;
			end
			chm_pkg::S_DIV:  if (hash_done) st_d = chm_pkg::S_HEAD;
			chm_pkg::S_HEAD: st_d = chm_pkg::S_WALK;
			chm_pkg::S_WALK: st_d = walk_end ? chm_pkg::S_ACT : chm_pkg::S_NODE;
			chm_pkg::S_NODE: st_d = (rd_key == key_q) ? chm_pkg::S_ACT : chm_pkg::S_WALK;
			chm_pkg::S_ACT: begin
				if (func_q == chm_pkg::FN_INSERT && !found_q && ft != '0)
					st_d = chm_pkg::S_POP;
				else
					st_d = chm_pkg::S_FIN;
			end
			chm_pkg::S_POP:  st_d = chm_pkg::S_FIN;
			chm_pkg::S_FIN:  if (out_load) st_d = chm_pkg::S_IDLE;
			default:         st_d = chm_pkg::S_IDLE;
		endcase
	end

	// memory commands; found_q doubles as the hit flag of the chain walk
	always_comb begin
		hash_start = 1'b0;
		head_rd    = 1'b0;
		head_we    = 1'b0;
		head_wdata = nlink_q;
		node_ctl   = '0;
		pool_ctl   = '0;
		kv_addr    = cur_q[IW-1:0];
		link_addr  = prev_q[IW-1:0];
		link_data  = nlink_q;
		unique case (st_q)
			chm_pkg::S_IDLE: begin
				if (req_go) begin
					if (chm_pkg::func_t'(req.func) == chm_pkg::FN_CLEAR)
						pool_ctl.clear = 1'b1;
					else
						hash_start = 1'b1;
				end
			end
			chm_pkg::S_DIV:  head_rd = hash_done;
			chm_pkg::S_WALK: node_ctl.rd = !walk_end;
			chm_pkg::S_ACT: begin
				case (func_q)
					chm_pkg::FN_INSERT: begin
						if (found_q)
							node_ctl.kv_we = 1'b1;
						else if (ft != '0)
							pool_ctl.pop = 1'b1;
					end
					chm_pkg::FN_REMOVE: begin
						if (found_q) begin
							pool_ctl.push = 1'b1;
							if (prev_q < NODE_END)
								node_ctl.link_we = 1'b1;
							else
								head_we = 1'b1;
						end
					end
					default: ;
				endcase
			end
			chm_pkg::S_POP: begin
				node_ctl.kv_we   = 1'b1;
				node_ctl.link_we = 1'b1;
				kv_addr          = pop_node;
				link_addr        = pop_node;
				link_data        = head_q;
				head_we          = 1'b1;
				head_wdata       = NW'(pop_node);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= chm_pkg::S_IDLE;
			ov_q     <= 1'b0;
			hvalid_q <= '0;
		end else begin
			st_q <= st_d;
			if (out_load)
				ov_q <= 1'b1;
			else if (rsp.ready)
				ov_q <= 1'b0;
			if (pool_ctl.clear)
				hvalid_q <= '0;
			else if (head_we)
				hvalid_q[bucket] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (head_we)
			head_mem[bucket] <= head_wdata;
		if (head_rd)
			head_rd_q <= head_mem[bucket];
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			chm_pkg::S_IDLE: begin
				func_q   <= chm_pkg::func_t'(req.func);
				key_q    <= req.key;
				val_q    <= req.value;
				status_q <= chm_pkg::ST_OK;
				found_q  <= 1'b0;
				vout_q   <= '0;
			end
			chm_pkg::S_HEAD: begin
				cur_q   <= hvalid_q[bucket] ? head_rd_q : NODE_END;
				head_q  <= hvalid_q[bucket] ? head_rd_q : NODE_END;
				prev_q  <= NODE_END;
				steps_q <= '0;
			end
			chm_pkg::S_NODE: begin
				if (rd_key == key_q) begin
					found_q <= 1'b1;
					nlink_q <= rd_link;
					nval_q  <= rd_val;
				end else begin
					prev_q  <= cur_q;
					cur_q   <= rd_link;
					steps_q <= steps_q + NW'(1);
				end
			end
			chm_pkg::S_ACT: begin
				case (func_q)
					chm_pkg::FN_INSERT: begin
						found_q <= 1'b0;
						if (!found_q && ft == '0)
							status_q <= chm_pkg::ST_FULL;
					end
					chm_pkg::FN_FIND: begin
						if (found_q)
							vout_q <= nval_q;
						else
							status_q <= chm_pkg::ST_NOT_FOUND;
					end
					chm_pkg::FN_REMOVE: begin
						found_q <= 1'b0;
						if (!found_q)
							status_q <= chm_pkg::ST_NOT_FOUND;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp.status         <= status_q;
			rsp.found          <= found_q;
			rsp.value_out      <= vout_q;
			rsp.entries_stored <= chm_pkg::ENT_W'(32'(NODES) - 32'(ft));
		end
	end

	assign rsp.valid = ov_q;

endmodule
